>>> rtl/ir_compensated_colour_temperature_defines.svh
// Assertion macros shared by the colour temperature RTL.
// Included by the top level; depends on nothing else.
`ifndef IR_COMPENSATED_COLOUR_TEMPERATURE_DEFINES_SVH
`define IR_COMPENSATED_COLOUR_TEMPERATURE_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define IRCCT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define IRCCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ircct_pkg.sv
// Types, status codes and constants for the colour temperature block.
// Used by every RTL module of the block; depends on nothing.
package ircct_pkg;

   localparam int unsigned CountWidth = 16;
   localparam int unsigned KelvinWidth = 28;
   localparam int unsigned SettingWidth = 8;
   localparam int unsigned DivSteps = KelvinWidth;

   localparam logic [11:0] TempSlope = 12'd3810;
   localparam logic [KelvinWidth-1:0] TempOffset = 28'd1391;
   localparam logic [CountWidth-1:0] DigitalMax = 16'd65535;
   localparam logic [8:0] CycleBase = 9'd256;
   localparam logic [8:0] AnalogCyclesMax = 9'd63;
   localparam logic [SettingWidth-1:0] SettingReset = 8'd255;

   // Status codes of a result.
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_CLEAR_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;
   localparam logic [1:0] STATUS_RED_INVALID = 2'd3;

   typedef struct packed {
      logic [CountWidth-1:0] clear_count;
      logic [CountWidth-1:0] red_count;
      logic [CountWidth-1:0] green_count;
      logic [CountWidth-1:0] blue_count;
   } req_type;

   typedef struct packed {
      logic [KelvinWidth-1:0] colour_temp_kelvin;
      logic [1:0] status;
   } rsp_type;

   // Corrected channels leaving the front stage.
   typedef struct packed {
      logic valid;
      logic [1:0] status;
      logic [CountWidth-1:0] red_corr;
      logic [CountWidth-1:0] blue_corr;
   } front_type;

   // Data handed from one divider cell to the next.
   typedef struct packed {
      logic valid;
      logic [1:0] status;
      logic [CountWidth-1:0] divisor;
      logic [CountWidth-1:0] remainder;
      logic [KelvinWidth-1:0] numer;
   } cell_data_type;

endpackage

>>> rtl/ircct_front.sv
// Front stage: saturation and clear checks, IR estimate and correction.
// Depends on ircct_pkg.
module ircct_front (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic req_accept,
   input  ircct_pkg::req_type req_data,
   input  logic [ircct_pkg::SettingWidth-1:0] setting,
   output ircct_pkg::front_type front_out
);

   logic [8:0] cycles;
   logic [15:0] sat_level;
   logic [17:0] chan_sum;
   logic [16:0] ir_est;
   logic [17:0] red_diff;
   logic [17:0] blue_diff;
   ircct_pkg::front_type front_in;
   ircct_pkg::front_type front_ff;

   // Saturation level from the integration cycle count.
   always_comb begin
      cycles = ircct_pkg::CycleBase - {1'b0, setting};
      if (cycles > ircct_pkg::AnalogCyclesMax) begin
         sat_level = ircct_pkg::DigitalMax;
      end else begin
         // 768 times the cycle count: 512 plus 256 times.
         sat_level = 16'({cycles, 9'd0}) + 16'({cycles, 8'd0});
      end
   end

   // IR estimate and the corrected red and blue channels.
   always_comb begin
      chan_sum = {2'b0, req_data.red_count} + {2'b0, req_data.green_count}
               + {2'b0, req_data.blue_count};
      if (chan_sum > {2'b0, req_data.clear_count}) begin
         ir_est = 17'((chan_sum - {2'b0, req_data.clear_count}) >> 1);
      end else begin
         ir_est = '0;
      end
      red_diff = {2'b0, req_data.red_count} - {1'b0, ir_est};
      blue_diff = {2'b0, req_data.blue_count} - {1'b0, ir_est};
   end

   // Status priority: clear zero, then saturation, then red not positive.
   always_comb begin
      front_in.valid = req_accept;
      front_in.red_corr = red_diff[15:0];
      front_in.blue_corr = blue_diff[17] ? '0 : blue_diff[15:0];
      if (req_data.clear_count == '0) begin
         front_in.status = ircct_pkg::STATUS_CLEAR_ZERO;
      end else if (req_data.clear_count >= sat_level) begin
         front_in.status = ircct_pkg::STATUS_SATURATED;
      end else if (red_diff[17] || (red_diff == '0)) begin
         front_in.status = ircct_pkg::STATUS_RED_INVALID;
      end else begin
         front_in.status = ircct_pkg::STATUS_OK;
      end
   end

   // Stage register; only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (enable) begin
         front_ff.valid <= front_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         front_ff.status <= front_in.status;
         front_ff.red_corr <= front_in.red_corr;
         front_ff.blue_corr <= front_in.blue_corr;
      end
   end

   assign front_out = front_ff;

endmodule

>>> rtl/ircct_div_cell.sv
// One restoring division cell: produces one quotient bit per transfer.
// Depends on ircct_pkg.
module ircct_div_cell (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  ircct_pkg::cell_data_type cell_in,
   output ircct_pkg::cell_data_type cell_out
);

   logic [16:0] rem_shift;
   logic [16:0] rem_sub;
   ircct_pkg::cell_data_type cell_in_next;
   ircct_pkg::cell_data_type cell_ff;

   // Bring down the next numerator bit and try to subtract the divisor.
   always_comb begin
      rem_shift = {cell_in.remainder, cell_in.numer[ircct_pkg::KelvinWidth-1]};
      rem_sub = rem_shift - {1'b0, cell_in.divisor};
      cell_in_next = cell_in;
      if (rem_shift >= {1'b0, cell_in.divisor}) begin
         cell_in_next.remainder = rem_sub[15:0];
         cell_in_next.numer = {cell_in.numer[ircct_pkg::KelvinWidth-2:0], 1'b1};
      end else begin
         cell_in_next.remainder = rem_shift[15:0];
         cell_in_next.numer = {cell_in.numer[ircct_pkg::KelvinWidth-2:0], 1'b0};
      end
   end

   // Cell register; only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff.valid <= cell_in_next.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cell_ff.status <= cell_in_next.status;
         cell_ff.divisor <= cell_in_next.divisor;
         cell_ff.remainder <= cell_in_next.remainder;
         cell_ff.numer <= cell_in_next.numer;
      end
   end

   assign cell_out = cell_ff;

endmodule

>>> rtl/ir_compensated_colour_temperature.sv
// Top level of the IR-compensated colour temperature block.
// Depends on ircct_pkg, ircct_front, ircct_div_cell and the defines header.
//
//   Channel   Ports                              Direction
//   req       req_valid, req_ready, req_data     in  (one RGBC sample)
//   rsp       rsp_valid, rsp_ready, rsp_data     out (kelvin and status)
//   csr       csr_wr_en, csr_wr_data             in  (integration setting)
//
// One sample may enter every cycle while req_ready is high; after its
// transfer the front stage loads at the transfer edge, then the multiplier
// stage, 28 divider cells and the output register follow in turn.
// The divider is a row of 28 cells, one quotient bit each.
// Reset clears all valid bits and sets the integration setting to 255.
// The row halts only while the output register is full, not taken, and the
// last cell holds a result; bubbles ahead of it halt with the row.
`include "ir_compensated_colour_temperature_defines.svh"

module ir_compensated_colour_temperature (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  ircct_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output ircct_pkg::rsp_type rsp_data,
   input  logic csr_wr_en,
   input  logic [ircct_pkg::SettingWidth-1:0] csr_wr_data
);

   logic [ircct_pkg::SettingWidth-1:0] setting_ff;
   logic out_load;
   logic pipe_en;
   logic req_accept;
   ircct_pkg::front_type front_q;
   ircct_pkg::cell_data_type mult_in;
   ircct_pkg::cell_data_type mult_ff;
   ircct_pkg::cell_data_type chain [0:ircct_pkg::DivSteps];
   ircct_pkg::cell_data_type last_cell;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   ircct_pkg::rsp_type rsp_data_ff;
   ircct_pkg::rsp_type rsp_data_in;

   // Integration setting register.
   always_ff @(posedge clock) begin
      if (reset) begin
         setting_ff <= ircct_pkg::SettingReset;
      end else if (csr_wr_en) begin
         setting_ff <= csr_wr_data;
      end
   end

   // Flow control: the row moves unless a held result blocks the last cell.
   assign last_cell = chain[ircct_pkg::DivSteps];
   assign out_load = !rsp_valid_ff || rsp_ready;
   assign pipe_en = out_load || !last_cell.valid;
   assign req_ready = pipe_en;
   assign req_accept = req_valid && req_ready;

   ircct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_en),
      .req_accept(req_accept),
      .req_data  (req_data),
      .setting   (setting_ff),
      .front_out (front_q)
   );

   // Multiplier stage: numerator is 3810 times corrected blue.
   always_comb begin
      mult_in.valid = front_q.valid;
      mult_in.status = front_q.status;
      mult_in.divisor = front_q.red_corr;
      mult_in.remainder = '0;
      mult_in.numer = {12'd0, front_q.blue_corr} * {16'd0, ircct_pkg::TempSlope};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff.valid <= 1'b0;
      end else if (pipe_en) begin
         mult_ff.valid <= mult_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mult_ff.status <= mult_in.status;
         mult_ff.divisor <= mult_in.divisor;
         mult_ff.remainder <= mult_in.remainder;
         mult_ff.numer <= mult_in.numer;
      end
   end

   assign chain[0] = mult_ff;

   // Row of division cells.
   for (genvar i = 0; i < ircct_pkg::DivSteps; i++) begin : g_cell
      ircct_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (pipe_en),
         .cell_in (chain[i]),
         .cell_out(chain[i+1])
      );
   end

   // Result formatting: add the offset, or zero for an invalid sample.
   always_comb begin
      rsp_valid_in = last_cell.valid;
      rsp_data_in.status = last_cell.status;
      if (last_cell.status == ircct_pkg::STATUS_OK) begin
         rsp_data_in.colour_temp_kelvin = last_cell.numer + ircct_pkg::TempOffset;
      end else begin
         rsp_data_in.colour_temp_kelvin = '0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Checks on the flow control and the result formatting.
   `IRCCT_ASSERT_IMPL(a_stall_cause, clock, reset, !req_ready, rsp_valid_ff && !rsp_ready && last_cell.valid, "input stalled without a blocked result")
   `IRCCT_ASSERT_NEXT(a_last_held, clock, reset, !pipe_en, last_cell.valid && $stable(last_cell.numer), "last cell changed during a stall")
   `IRCCT_ASSERT_IMPL(a_invalid_zero, clock, reset, rsp_valid_ff && (rsp_data_ff.status != ircct_pkg::STATUS_OK), rsp_data_ff.colour_temp_kelvin == '0, "invalid sample with non-zero temperature")
   `IRCCT_ASSERT_IMPL(a_ok_offset, clock, reset, rsp_valid_ff && (rsp_data_ff.status == ircct_pkg::STATUS_OK), rsp_data_ff.colour_temp_kelvin >= ircct_pkg::TempOffset, "valid temperature below the offset")

endmodule
